// ===== sv/nalsplit_pkg.sv =====
// Shared types, codes and constants for the Annex-B NAL unit splitter.
`default_nettype none

package nalsplit_pkg;

	// Default largest buffer length in bytes before positions saturate.
	localparam int unsigned MAX_BUFFER_BYTES_DEF = 65536;

	// Codec selection codes.
	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	// Normalized unit kinds.
	localparam logic [2:0] KIND_UNKNOWN = 3'd0;
	localparam logic [2:0] KIND_SPS     = 3'd1;
	localparam logic [2:0] KIND_PPS     = 3'd2;
	localparam logic [2:0] KIND_VPS     = 3'd3;
	localparam logic [2:0] KIND_SEI     = 3'd4;
	localparam logic [2:0] KIND_AUD     = 3'd5;
	localparam logic [2:0] KIND_KEY     = 3'd6;
	localparam logic [2:0] KIND_SLICE   = 3'd7;

	// Buffer status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_NO_START = 2'd2;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

	// H.264 header type codes.
	localparam logic [5:0] AVC_SLICE = 6'd1;
	localparam logic [5:0] AVC_IDR   = 6'd5;
	localparam logic [5:0] AVC_SEI   = 6'd6;
	localparam logic [5:0] AVC_SPS   = 6'd7;
	localparam logic [5:0] AVC_PPS   = 6'd8;
	localparam logic [5:0] AVC_AUD   = 6'd9;

	// H.265 header type codes.
	localparam logic [5:0] HEVC_SLICE_LAST = 6'd9;
	localparam logic [5:0] HEVC_IRAP_FIRST = 6'd16;
	localparam logic [5:0] HEVC_IRAP_LAST  = 6'd21;
	localparam logic [5:0] HEVC_VPS        = 6'd32;
	localparam logic [5:0] HEVC_SPS        = 6'd33;
	localparam logic [5:0] HEVC_PPS        = 6'd34;
	localparam logic [5:0] HEVC_SEI_PREFIX = 6'd39;
	localparam logic [5:0] HEVC_SEI_SUFFIX = 6'd40;

	// One stream byte request.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_buffer;
	} nal_item_t;

	// One result request.
	typedef struct packed {
		logic        unit_valid;
		logic [15:0] unit_offset;
		logic [15:0] unit_length;
		logic [5:0]  raw_type;
		logic [2:0]  unit_kind;
		logic        is_key;
		logic        buffer_done;
		logic [15:0] unit_count;
		logic [1:0]  buffer_status;
	} nal_result_t;

endpackage

`default_nettype wire

// ===== sv/annexb_nal_unit_splitter.sv =====
// Top level of the Annex-B NAL unit splitter: start code search and unit reporting.
// A byte accepted is held in the input register, and its result, if any, is presented
// from the result register. Throughput: one byte per cycle, unless a byte's result
// must wait while the result register holds a stalled request.
// Reset: arst_n clears all parse state, the codec selection (H.264) and both valid
// registers at once; no clearing pass is needed.
`default_nettype none

module annexb_nal_unit_splitter import nalsplit_pkg::*; #(
	parameter int unsigned MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte channel.
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire nal_item_t   src_item,
	// Result channel.
	output logic             res_valid,
	input  wire logic        res_stall,
	output nal_result_t      res_item,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	// Positions run up to MAX_BUFFER_BYTES + 1 (a unit start after a saturated byte).
	localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES + 2);
	localparam int unsigned EXT_W = (POS_W > 16) ? POS_W : 16;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BUFFER_BYTES);

	// Configuration register.
	logic codec_q;

	// Input register.
	logic      item_valid_s1;
	nal_item_t item_s1;

	// Parse state.
	logic [POS_W-1:0] pos_q;
	logic [1:0]       zrun_q;
	logic             inside_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] trim_q;
	logic [7:0]       hdr_q;
	logic [15:0]      count_q;
	logic             ovf_q;

	// Next parse state.
	logic [POS_W-1:0] pos_n;
	logic [1:0]       zrun_n;
	logic             inside_n;
	logic [POS_W-1:0] start_n;
	logic [POS_W-1:0] trim_n;
	logic [7:0]       hdr_n;
	logic [15:0]      count_n;
	logic             ovf_n;

	// Unit close path.
	logic             is_start;
	logic             close_old;
	logic             try_close;
	logic [POS_W-1:0] cl_start;
	logic [POS_W-1:0] cl_trim;
	logic [POS_W-1:0] cl_len;
	logic             len_ok;
	logic             deliver;
	logic             short_buf;
	logic [5:0]       utype;
	logic [2:0]       ukind;
	logic             ukey;
	logic [EXT_W-1:0] start_ext;
	logic [EXT_W-1:0] len_ext;
	logic             produce;
	logic             advance;
	logic             res_free;
	nal_result_t      result;

	// Result register.
	logic        res_valid_q;
	nal_result_t res_q;

	assign cfg_ready = 1'b1;

	// The result register frees up when empty or when its request is taken.
	assign res_free  = !res_valid_q || !res_stall;
	assign advance   = item_valid_s1 && (!produce || res_free);
	assign src_stall = item_valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Byte step: start code detection, zero run, unit bounds and header capture.
	always_comb begin
		ovf_n    = ovf_q || (pos_q == MAX_POS);
		pos_n    = (pos_q == MAX_POS) ? MAX_POS : pos_q + POS_W'(1);
		hdr_n    = (inside_q && pos_q == start_q) ? item_s1.data_byte : hdr_q;
		is_start = (item_s1.data_byte == 8'h01) && (zrun_q == 2'd2);
		inside_n = inside_q;
		start_n  = start_q;
		trim_n   = trim_q;
		zrun_n   = zrun_q;
		if (is_start) begin
			inside_n = 1'b1;
			start_n  = pos_q + POS_W'(1);
			trim_n   = pos_q + POS_W'(1);
			zrun_n   = 2'd0;
		end else if (item_s1.data_byte == 8'h00) begin
			if (zrun_q != 2'd2) begin
				zrun_n = zrun_q + 2'd1;
			end
		end else begin
			zrun_n = 2'd0;
			if (inside_q) begin
				trim_n = pos_q + POS_W'(1);
			end
		end
	end

	// A start code closes the previous unit; otherwise the buffer end closes the open one.
	always_comb begin
		short_buf = pos_n < POS_W'(4);
		close_old = is_start && inside_q;
		try_close = close_old || (item_s1.last_in_buffer && inside_n);
		cl_start  = close_old ? start_q : start_n;
		cl_trim   = close_old ? trim_q : trim_n;
		cl_len    = cl_trim - cl_start;
		len_ok    = (cl_trim > cl_start) &&
			((codec_q == CODEC_H264) || (cl_len >= POS_W'(2)));
		deliver   = try_close && len_ok && !(item_s1.last_in_buffer && short_buf);
		count_n   = (deliver && count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
		produce   = deliver || item_s1.last_in_buffer;
	end

	// Header decode into raw type, kind and key flag.
	always_comb begin
		ukind = KIND_UNKNOWN;
		ukey  = 1'b0;
		if (codec_q == CODEC_H265) begin
			utype = hdr_n[6:1];
			case (utype) inside
				HEVC_VPS:                          ukind = KIND_VPS;
				HEVC_SPS:                          ukind = KIND_SPS;
				HEVC_PPS:                          ukind = KIND_PPS;
				HEVC_SEI_PREFIX, HEVC_SEI_SUFFIX:  ukind = KIND_SEI;
				[HEVC_IRAP_FIRST:HEVC_IRAP_LAST]: begin
					ukind = KIND_KEY;
					ukey  = 1'b1;
				end
				[6'd0:HEVC_SLICE_LAST]:            ukind = KIND_SLICE;
				default:                           ukind = KIND_UNKNOWN;
			endcase
		end else begin
			utype = {1'b0, hdr_n[4:0]};
			case (utype)
				AVC_SPS:   ukind = KIND_SPS;
				AVC_PPS:   ukind = KIND_PPS;
				AVC_SEI:   ukind = KIND_SEI;
				AVC_AUD:   ukind = KIND_AUD;
				AVC_IDR: begin
					ukind = KIND_KEY;
					ukey  = 1'b1;
				end
				AVC_SLICE: ukind = KIND_SLICE;
				default:   ukind = KIND_UNKNOWN;
			endcase
		end
	end

	// Result assembly with saturated offset and length.
	always_comb begin
		start_ext = EXT_W'(cl_start);
		len_ext   = EXT_W'(cl_len);
		result    = '0;
		if (deliver) begin
			result.unit_valid  = 1'b1;
			result.unit_offset = (start_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : start_ext[15:0];
			result.unit_length = (len_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
			result.raw_type    = utype;
			result.unit_kind   = ukind;
			result.is_key      = ukey;
		end
		if (item_s1.last_in_buffer) begin
			result.buffer_done = 1'b1;
			if (short_buf) begin
				result.unit_count    = 16'd0;
				result.buffer_status = STATUS_SHORT;
			end else begin
				result.unit_count = count_n;
				if (ovf_n) begin
					result.buffer_status = STATUS_TOO_LONG;
				end else if (!inside_n) begin
					result.buffer_status = STATUS_NO_START;
				end else begin
					result.buffer_status = STATUS_OK;
				end
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= CODEC_H264;
		end else if (cfg_valid && cfg_ready) begin
			codec_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			item_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	// Parse state; the last byte of a buffer clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			zrun_q   <= '0;
			inside_q <= 1'b0;
			start_q  <= '0;
			trim_q   <= '0;
			hdr_q    <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_in_buffer) begin
				pos_q    <= '0;
				zrun_q   <= '0;
				inside_q <= 1'b0;
				start_q  <= '0;
				trim_q   <= '0;
				hdr_q    <= '0;
				count_q  <= '0;
				ovf_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				zrun_q   <= zrun_n;
				inside_q <= inside_n;
				start_q  <= start_n;
				trim_q   <= trim_n;
				hdr_q    <= hdr_n;
				count_q  <= count_n;
				ovf_q    <= ovf_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && advance && produce) begin
			res_q <= result;
		end
	end

endmodule

`default_nettype wire
